[hdl/asat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package asat_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] mac_address;
    logic [15:0] auth_seq;
  } item_t;

  typedef struct packed {
    logic [3:0]  response;
    logic [15:0] response_seq;
    logic        is_last;
    logic [11:0] assoc_id;
    logic [1:0]  notify;
  } result_t;

  localparam logic [2:0] KIND_AUTH    = 3'd0;
  localparam logic [2:0] KIND_DEAUTH  = 3'd1;
  localparam logic [2:0] KIND_ASSOC   = 3'd2;
  localparam logic [2:0] KIND_REASSOC = 3'd3;
  localparam logic [2:0] KIND_DATA    = 3'd4;

  localparam logic [3:0] RESP_AUTH_OK    = 4'd0;
  localparam logic [3:0] RESP_AUTH_OOS   = 4'd1;
  localparam logic [3:0] RESP_NOT_AUTH   = 4'd2;
  localparam logic [3:0] RESP_ASSOC_OK   = 4'd3;
  localparam logic [3:0] RESP_REASSOC_OK = 4'd4;
  localparam logic [3:0] RESP_NONE       = 4'd5;
  localparam logic [3:0] RESP_FORWARD    = 4'd6;
  localparam logic [3:0] RESP_DROP       = 4'd7;
  localparam logic [3:0] RESP_FULL       = 4'd8;

  localparam logic [1:0] ST_NOT_AUTH = 2'd0;
  localparam logic [1:0] ST_AUTH     = 2'd1;
  localparam logic [1:0] ST_ASSOC    = 2'd2;

  localparam logic [1:0] NOTIFY_NONE   = 2'd0;
  localparam logic [1:0] NOTIFY_ASSOC  = 2'd1;
  localparam logic [1:0] NOTIFY_DISASC = 2'd2;

  localparam int MCAST_BIT = 40;
  localparam logic [3:0] AUTH_STEPS_RESET = 4'd4;
  localparam logic [1:0] REG_AUTH_STEPS = 2'd0;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_READ,
    BK_EXEC,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

[hdl/asat_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue of accepted commands; the back end pops one at a time.
module asat_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  asat_pkg::item_t push_item,
  output logic            full,
  input  wire             pop,
  output logic            not_empty,
  output asat_pkg::item_t head
);
  asat_pkg::item_t slot [2];
  logic            rd_ptr, wr_ptr;
  logic [1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_item;
  end

  assign full      = count[1];
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];
endmodule
`default_nettype wire

[hdl/asat_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Walks the table one entry per cycle to find the station and the lowest
// free entry, then reads the entry record and does one read-modify-write.
module asat_back #(
  parameter int STATIONS = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  wire  [3:0]        auth_steps,
  input  wire               avail,
  input  asat_pkg::item_t   item,
  output logic              pop,
  output logic              done,
  output asat_pkg::result_t result
);
  localparam int IW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int CW = $clog2(STATIONS + 1);
  localparam int RW = 2 + 16 + 12;

  asat_pkg::back_state_t state, state_next;

  logic [STATIONS-1:0] valid;
  logic [47:0]         mac_mem [STATIONS];
  logic [RW-1:0]       rec_mem [STATIONS];

  asat_pkg::item_t cur;
  logic [CW-1:0]   scan;
  logic [IW-1:0]   idx;
  logic            found, have_free;
  logic [IW-1:0]   hit_idx, free_idx;
  logic [47:0]     mac_rd;
  logic [RW-1:0]   rec_rd;
  logic [2:0]      new_count;
  logic [7:0]      aid_index;

  assign idx = scan[IW-1:0];

  // The MAC read is registered; the compare of entry scan-1 happens in the next cycle.
  logic          cmp_valid;
  logic          cmp_v;
  logic [IW-1:0] cmp_idx;

  always_ff @(posedge clk) begin
    mac_rd <= mac_mem[idx];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      asat_pkg::BK_IDLE:   if (avail) state_next = asat_pkg::BK_SEARCH;
      asat_pkg::BK_SEARCH: if (!cmp_valid && scan == CW'(STATIONS)) state_next = asat_pkg::BK_READ;
      asat_pkg::BK_READ:   state_next = asat_pkg::BK_EXEC;
      asat_pkg::BK_EXEC:   state_next = asat_pkg::BK_DONE;
      asat_pkg::BK_DONE:   state_next = asat_pkg::BK_IDLE;
      default:             state_next = asat_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    done = 1'b0;
    unique case (state)
      asat_pkg::BK_IDLE: pop  = avail;
      asat_pkg::BK_DONE: done = 1'b1;
      default: ;
    endcase
  end

  logic [IW-1:0] sel_idx;
  assign sel_idx = found ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    rec_rd <= rec_mem[sel_idx];
  end

  // Execute stage.
  logic [1:0]  st;
  logic [15:0] exp_seq;
  logic [11:0] aid;
  logic        hit;
  logic [2:0]  cnt_inc;
  logic [7:0]  idx_inc;
  asat_pkg::result_t res;
  logic        wr_en, claim;
  logic [RW-1:0] wr_rec;
  logic [16:0] seq_p1;

  always_comb begin
    cnt_inc = new_count + 3'd1;
    idx_inc = aid_index + 8'd1;
    hit     = found;
    st      = rec_rd[RW-1 -: 2];
    exp_seq = rec_rd[27:12];
    aid     = rec_rd[11:0];
    claim   = 1'b0;
    wr_en   = 1'b0;
    seq_p1  = {1'b0, cur.auth_seq} + 17'd1;
    res     = '{response: asat_pkg::RESP_NONE, response_seq: 16'd0, is_last: 1'b0,
                assoc_id: 12'd0, notify: asat_pkg::NOTIFY_NONE};
    unique case (cur.kind) inside
      asat_pkg::KIND_AUTH: begin
        if (!found && !have_free) begin
          res.response = asat_pkg::RESP_FULL;
        end else begin
          if (!found) begin
            claim   = 1'b1;
            hit     = 1'b1;
            st      = asat_pkg::ST_NOT_AUTH;
            exp_seq = 16'd1;
            aid     = {1'b0, cnt_inc, idx_inc};
          end
          wr_en = 1'b1;
          if (cur.auth_seq == 16'd1) begin
            if (st == asat_pkg::ST_ASSOC) res.notify = asat_pkg::NOTIFY_DISASC;
            st      = asat_pkg::ST_NOT_AUTH;
            exp_seq = 16'd1;
          end
          if (cur.auth_seq != exp_seq) begin
            res.response = asat_pkg::RESP_AUTH_OOS;
            exp_seq      = 16'd1;
          end else begin
            res.response     = asat_pkg::RESP_AUTH_OK;
            res.response_seq = seq_p1[15:0];
            res.is_last      = (seq_p1 == {13'd0, auth_steps});
            if (res.is_last) begin
              if (st == asat_pkg::ST_ASSOC) res.notify = asat_pkg::NOTIFY_DISASC;
              st = asat_pkg::ST_AUTH;
            end else begin
              exp_seq = exp_seq + 16'd2;
            end
          end
        end
      end
      asat_pkg::KIND_DEAUTH: begin
        if (found) begin
          wr_en = 1'b1;
          if (st == asat_pkg::ST_ASSOC) res.notify = asat_pkg::NOTIFY_DISASC;
          st      = asat_pkg::ST_NOT_AUTH;
          exp_seq = 16'd1;
        end
      end
      asat_pkg::KIND_ASSOC, asat_pkg::KIND_REASSOC: begin
        if (!found || st == asat_pkg::ST_NOT_AUTH) begin
          res.response = asat_pkg::RESP_NOT_AUTH;
        end else begin
          wr_en = 1'b1;
          if (cur.kind == asat_pkg::KIND_ASSOC) begin
            if (st != asat_pkg::ST_ASSOC) res.notify = asat_pkg::NOTIFY_ASSOC;
            res.response = asat_pkg::RESP_ASSOC_OK;
            res.assoc_id = aid;
          end else begin
            res.response = asat_pkg::RESP_REASSOC_OK;
          end
          st = asat_pkg::ST_ASSOC;
        end
      end
      asat_pkg::KIND_DATA: begin
        if (cur.mac_address[asat_pkg::MCAST_BIT] || (found && st == asat_pkg::ST_ASSOC))
          res.response = asat_pkg::RESP_FORWARD;
        else
          res.response = asat_pkg::RESP_DROP;
      end
      default: ;
    endcase
    wr_rec = {st, exp_seq, aid};
    if (!hit) wr_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= asat_pkg::BK_IDLE;
      valid     <= '0;
      new_count <= 3'd0;
      aid_index <= 8'd1;
      scan      <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      have_free <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        asat_pkg::BK_IDLE: begin
          scan      <= '0;
          cmp_valid <= 1'b0;
          found     <= 1'b0;
          have_free <= 1'b0;
        end
        asat_pkg::BK_SEARCH: begin
          cmp_valid <= (scan != CW'(STATIONS));
          if (scan != CW'(STATIONS)) begin
            cmp_v   <= valid[idx];
            cmp_idx <= idx;
            if (!valid[idx] && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= idx;
            end
            scan <= scan + CW'(1);
          end
          if (cmp_valid && cmp_v && !found && mac_rd == cur.mac_address) begin
            found   <= 1'b1;
            hit_idx <= cmp_idx;
          end
        end
        asat_pkg::BK_EXEC: begin
          if (claim) begin
            valid[free_idx] <= 1'b1;
            new_count       <= cnt_inc;
            aid_index       <= idx_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= item;
    if (state == asat_pkg::BK_EXEC) result <= res;
    if (state == asat_pkg::BK_EXEC && wr_en) rec_mem[sel_idx] <= wr_rec;
    if (state == asat_pkg::BK_EXEC && claim) mac_mem[free_idx] <= cur.mac_address;
  end
endmodule
`default_nettype wire

[hdl/ap_station_auth_assoc_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Station table for an access point. A command is taken when start is high
// and busy is low; its one result appears for a single cycle with done high
// and cannot be held off. Each command runs an address search that reads one
// table entry per cycle and finishes with a registered compare, followed by
// one record read and one record write. A two-entry command queue lets a new
// command be taken while another is being worked.
module ap_station_auth_assoc_table_unit #(
  parameter int STATIONS = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  asat_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output asat_pkg::result_t result,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [1:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [3:0]      auth_steps;
  logic            q_full, q_avail, q_pop;
  asat_pkg::item_t q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == {asat_pkg::REG_AUTH_STEPS}) ? {28'd0, auth_steps} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) auth_steps <= asat_pkg::AUTH_STEPS_RESET;
    else if (psel && penable && pwrite && paddr == asat_pkg::REG_AUTH_STEPS)
      auth_steps <= pwdata[3:0];
  end

  assign busy = q_full;

  asat_front u_front (
    .clk(clk), .rst(rst), .push(start && !q_full), .push_item(item), .full(q_full),
    .pop(q_pop), .not_empty(q_avail), .head(q_head)
  );

  asat_back #(.STATIONS(STATIONS)) u_back (
    .clk(clk), .rst(rst), .auth_steps(auth_steps), .avail(q_avail), .item(q_head),
    .pop(q_pop), .done(done), .result(result)
  );
endmodule
`default_nettype wire

[hdl/asat_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module asat_checker (
  input wire               clk,
  input wire               rst,
  input wire               done,
  input asat_pkg::result_t result
);
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");
  a_resp_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.response <= asat_pkg::RESP_FULL)
    else $error("response code out of range");
  a_seq_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.response != asat_pkg::RESP_AUTH_OK |-> result.response_seq == 16'd0)
    else $error("response_seq set outside auth ok");
  a_no_done_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result right after reset");
endmodule

bind ap_station_auth_assoc_table_unit asat_checker u_chk (
  .clk(clk), .rst(rst), .done(done), .result(result)
);
`default_nettype wire
